### hw/rtl/rc4_pkg.sv
// ============================================================================
// RC4 package
// Shared constants, payload types, datapath commands and controller states
// for the RC4 stream cipher engine.
// ============================================================================
package rc4_pkg;

   localparam int PERM_SIZE = 256;
   localparam int KEY_MAX   = 256;
   localparam int KEY_CNT_W = 9;

   localparam logic REQ_KEY  = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] byte_value;
      logic       key_last;
   } rc4_req_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic [7:0] keystream_byte;
   } rc4_rsp_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_KEY_STORE,
      DP_KEY_LAST,
      DP_KS_READ,
      DP_KS_ACC,
      DP_KS_SWAP1,
      DP_KS_SWAP2,
      DP_DATA_START,
      DP_GEN_J,
      DP_GEN_SWAP1,
      DP_GEN_SWAP2
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
   } rc4_cmd_type;

   typedef struct packed {
      logic ks_done;
      logic out_free;
   } rc4_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KS_READ,
      ST_KS_ACC,
      ST_KS_SWAP1,
      ST_KS_SWAP2,
      ST_GEN_J,
      ST_GEN_SWAP1,
      ST_GEN_SWAP2
   } rc4_state_type;

endpackage

### hw/rtl/rc4_stream_cipher.sv
// ============================================================================
// RC4 stream cipher
// Key loading, key schedule and keystream generation with a controller and
// a datapath around one permutation memory.
//
//   Channel  Ports                          Moves
//   req      req_valid/req_stall/req_data   key byte or data byte, per item
//   rsp      rsp_valid/rsp_stall/rsp_data   cipher and keystream byte
//
// A key byte is stored while the controller stays idle. The final key byte
// starts the schedule, which reads, accumulates and swaps each permutation
// entry on the single write port. A data item steps through the registered
// memory reads and the two writes of the swap before the next item is taken.
// Reset is synchronous; the permutation returns to identity at once through
// per-entry valid bits, with no clearing pass.
// A data item whose result meets a stalled full output waits in its last step.
// ============================================================================
module rc4_stream_cipher import rc4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rc4_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rc4_rsp_type rsp_data
);

   rc4_cmd_type    cmd;
   rc4_status_type status;

   rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rc4_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/rc4_datapath.sv
// ============================================================================
// RC4 datapath
// Permutation memory, key store, schedule and generator indices, and the
// output register. Every step is selected by the controller's command.
// ============================================================================
module rc4_datapath import rc4_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  rc4_cmd_type    cmd,
   input  rc4_req_type    req_data,
   output rc4_status_type status,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rc4_rsp_type    rsp_data
);

   // Permutation memory; an entry whose valid bit is clear reads as its index.
   logic [7:0]           perm_mem [PERM_SIZE];
   logic [PERM_SIZE-1:0] pvalid_ff;
   logic [7:0]           key_mem [KEY_MAX];

   logic [7:0]           rd0_ff;
   logic [7:0]           rd1_ff;
   logic [7:0]           key_rd_ff;
   logic [7:0]           sa_ff;
   logic [7:0]           sb_ff;
   logic [7:0]           t_ff;
   logic [7:0]           acc_ff;
   logic [7:0]           n_ff;
   logic [7:0]           kpos_ff;
   logic [KEY_CNT_W-1:0] key_len_ff;
   logic [KEY_CNT_W-1:0] key_cnt_ff;
   logic [7:0]           gi_ff;
   logic [7:0]           gj_ff;
   logic [7:0]           data_ff;
   logic                 rsp_valid_ff;
   rc4_rsp_type          rsp_data_ff;

   logic                 wr_en;
   logic [7:0]           wr_addr;
   logic [7:0]           wr_data;
   logic                 rd0_en;
   logic [7:0]           rd0_addr;
   logic                 rd1_en;
   logic [7:0]           rd1_addr;
   logic [7:0]           acc_sum;
   logic [7:0]           ks_byte;
   logic                 key_wr;
   logic                 key_room;
   logic [KEY_CNT_W-1:0] key_cnt_inc;
   logic [7:0]           kpos_next;

   assign key_room    = key_cnt_ff < KEY_CNT_W'(KEY_MAX);
   assign key_cnt_inc = key_room ? key_cnt_ff + KEY_CNT_W'(1) : key_cnt_ff;
   assign key_wr      = ((cmd.op == DP_KEY_STORE) || (cmd.op == DP_KEY_LAST)) && key_room;
   assign acc_sum     = acc_ff + rd0_ff + key_rd_ff;
   assign kpos_next   = ({1'b0, kpos_ff} + KEY_CNT_W'(1) >= key_len_ff) ? 8'd0
                                                                       : kpos_ff + 8'd1;

   // After the swap, S[i] holds the old S[j] and S[j] the old S[i]; the
   // keystream read saw the memory before the swap, so forward those values.
   always_comb begin
      if (t_ff == gj_ff) begin
         ks_byte = sa_ff;
      end else if (t_ff == gi_ff) begin
         ks_byte = sb_ff;
      end else begin
         ks_byte = rd0_ff;
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = n_ff;
      wr_data  = rd1_ff;
      rd0_en   = 1'b0;
      rd0_addr = n_ff;
      rd1_en   = 1'b0;
      rd1_addr = acc_sum;
      case (cmd.op)
         DP_KS_READ: begin
            rd0_en = 1'b1;
         end
         DP_KS_ACC: begin
            rd1_en = 1'b1;
         end
         DP_KS_SWAP1: begin
            wr_en = 1'b1;
         end
         DP_KS_SWAP2: begin
            wr_en   = 1'b1;
            wr_addr = acc_ff;
            wr_data = sa_ff;
         end
         DP_DATA_START: begin
            rd0_en   = 1'b1;
            rd0_addr = gi_ff + 8'd1;
         end
         DP_GEN_J: begin
            rd1_en   = 1'b1;
            rd1_addr = gj_ff + rd0_ff;
         end
         DP_GEN_SWAP1: begin
            wr_en    = 1'b1;
            wr_addr  = gi_ff;
            rd0_en   = 1'b1;
            rd0_addr = sa_ff + rd1_ff;
         end
         DP_GEN_SWAP2: begin
            wr_en   = 1'b1;
            wr_addr = gj_ff;
            wr_data = sa_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd0_en) begin
         rd0_ff <= pvalid_ff[rd0_addr] ? perm_mem[rd0_addr] : rd0_addr;
      end
      if (rd1_en) begin
         rd1_ff <= pvalid_ff[rd1_addr] ? perm_mem[rd1_addr] : rd1_addr;
      end
   end

   // Clearing the valid bits restores the identity permutation.
   always_ff @(posedge clock) begin
      if (reset || (cmd.op == DP_KEY_LAST)) begin
         pvalid_ff <= '0;
      end else if (wr_en) begin
         pvalid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (key_wr) begin
         key_mem[key_cnt_ff[7:0]] <= req_data.byte_value;
      end
      if (cmd.op == DP_KS_READ) begin
         key_rd_ff <= key_mem[kpos_ff];
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_KS_ACC: begin
            sa_ff  <= rd0_ff;
            acc_ff <= acc_sum;
         end
         DP_KEY_LAST: begin
            acc_ff     <= 8'd0;
            n_ff       <= 8'd0;
            kpos_ff    <= 8'd0;
            key_len_ff <= key_cnt_inc;
         end
         DP_KS_SWAP2: begin
            n_ff    <= n_ff + 8'd1;
            kpos_ff <= kpos_next;
         end
         DP_DATA_START: begin
            data_ff <= req_data.byte_value;
         end
         DP_GEN_J: begin
            sa_ff <= rd0_ff;
         end
         DP_GEN_SWAP1: begin
            sb_ff <= rd1_ff;
            t_ff  <= sa_ff + rd1_ff;
         end
         default: begin
         end
      endcase
      if (cmd.out_load) begin
         rsp_data_ff.cipher_byte    <= data_ff ^ ks_byte;
         rsp_data_ff.keystream_byte <= ks_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_cnt_ff   <= '0;
         gi_ff        <= 8'd0;
         gj_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (cmd.op)
            DP_KEY_STORE: begin
               key_cnt_ff <= key_cnt_inc;
            end
            DP_KEY_LAST: begin
               key_cnt_ff <= '0;
               gi_ff      <= 8'd0;
               gj_ff      <= 8'd0;
            end
            DP_DATA_START: begin
               gi_ff <= gi_ff + 8'd1;
            end
            DP_GEN_J: begin
               gj_ff <= gj_ff + rd0_ff;
            end
            default: begin
            end
         endcase
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.ks_done  = n_ff == 8'(PERM_SIZE - 1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

### hw/rtl/rc4_ctrl.sv
// ============================================================================
// RC4 controller
// Sequences key loads, the key schedule and the generator step, and issues
// one datapath command per cycle.
// ============================================================================
module rc4_ctrl import rc4_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  rc4_req_type    req_data,
   output logic           req_stall,
   input  rc4_status_type status,
   output rc4_cmd_type    cmd
);

   rc4_state_type state_ff;
   rc4_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = DP_IDLE;
      cmd.out_load = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.req_type == REQ_DATA) begin
                  cmd.op   = DP_DATA_START;
                  state_in = ST_GEN_J;
               end else if (req_data.key_last) begin
                  cmd.op   = DP_KEY_LAST;
                  state_in = ST_KS_READ;
               end else begin
                  cmd.op = DP_KEY_STORE;
               end
            end
         end
         ST_KS_READ: begin
            cmd.op   = DP_KS_READ;
            state_in = ST_KS_ACC;
         end
         ST_KS_ACC: begin
            cmd.op   = DP_KS_ACC;
            state_in = ST_KS_SWAP1;
         end
         ST_KS_SWAP1: begin
            cmd.op   = DP_KS_SWAP1;
            state_in = ST_KS_SWAP2;
         end
         ST_KS_SWAP2: begin
            cmd.op   = DP_KS_SWAP2;
            state_in = status.ks_done ? ST_IDLE : ST_KS_READ;
         end
         ST_GEN_J: begin
            cmd.op   = DP_GEN_J;
            state_in = ST_GEN_SWAP1;
         end
         ST_GEN_SWAP1: begin
            cmd.op   = DP_GEN_SWAP1;
            state_in = ST_GEN_SWAP2;
         end
         ST_GEN_SWAP2: begin
            // Repeating this step while the output is full rewrites the same value.
            cmd.op = DP_GEN_SWAP2;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/rc4_checker.sv
// ============================================================================
// RC4 port checker
// Checks the output handshake and the item timing seen at the top level.
// ============================================================================
module rc4_checker import rc4_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input rc4_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rc4_rsp_type rsp_data
);

   logic data_accept;

   assign data_accept = req_valid && !req_stall && (req_data.req_type == REQ_DATA);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   a_busy_after_data: assert property (@(posedge clock) disable iff (reset)
      data_accept |=> req_stall)
      else $error("new item taken while a data item is in progress");

   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      data_accept && !rsp_valid |-> ##4 rsp_valid)
      else $error("result item missing four cycles after a data item");

   a_key_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.req_type == REQ_KEY) && !rsp_valid
      |=> !rsp_valid)
      else $error("key item produced a result item");

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// RC4 stream cipher testbench
// Loads keys byte by byte and encrypts data items. Every result is compared
// with the cipher and keystream bytes computed by a scoreboard model. Random
// sender gaps and receiver stalls are applied throughout the run.
// ============================================================================
module tb_top import rc4_pkg::*;;

   localparam int DRAIN_CYCLES = 1100;   // outlasts the key schedule started by a final key byte
   localparam int IDLE_LIMIT   = 20000;
   localparam int RANDOM_ITEMS = 660;

   class rc4_scoreboard;
      bit [7:0]    perm [PERM_SIZE];
      bit [7:0]    key_bytes [KEY_MAX];
      bit [8:0]    key_cnt;
      bit [7:0]    gen_i;
      bit [7:0]    gen_j;
      rc4_rsp_type expected_q [$];
      int          errors;
      int          requests_seen;
      int          schedules_run;
      int          results_checked;

      function new();
         for (int k = 0; k < PERM_SIZE; k++) perm[k] = k[7:0];
         key_cnt = '0;
         gen_i = '0;
         gen_j = '0;
      endfunction

      function void swap_entries(bit [7:0] a, bit [7:0] b);
         bit [7:0] t;
         t = perm[a];
         perm[a] = perm[b];
         perm[b] = t;
      endfunction

      // The schedule always starts from identity, so earlier keys leave no trace.
      function void run_key_schedule(int len);
         bit [7:0] acc;
         int       kpos;
         acc = '0;
         kpos = 0;
         for (int k = 0; k < PERM_SIZE; k++) perm[k] = k[7:0];
         for (int n = 0; n < PERM_SIZE; n++) begin
            acc = acc + perm[n] + key_bytes[kpos];
            swap_entries(n[7:0], acc);
            kpos++;
            if (kpos >= len) kpos = 0;
         end
      endfunction

      function void note_request(rc4_req_type it);
         rc4_rsp_type rsp;
         bit [7:0]    ks;
         requests_seen++;
         if (it.req_type == REQ_KEY) begin
            // Key bytes beyond the store are dropped; the count stays full.
            if (key_cnt < KEY_MAX) begin
               key_bytes[key_cnt[7:0]] = it.byte_value;
               key_cnt++;
            end
            if (it.key_last) begin
               run_key_schedule((key_cnt == 0) ? 1 : int'(key_cnt));
               key_cnt = '0;
               gen_i = '0;
               gen_j = '0;
               schedules_run++;
            end
         end else begin
            gen_i = gen_i + 8'd1;
            gen_j = gen_j + perm[gen_i];
            swap_entries(gen_i, gen_j);
            ks = perm[8'(perm[gen_i] + perm[gen_j])];
            rsp.keystream_byte = ks;
            rsp.cipher_byte = it.byte_value ^ ks;
            expected_q.insert(expected_q.size(), rsp);
         end
      endfunction

      function void check_response(rc4_rsp_type got);
         rc4_rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, got cipher %02h keystream %02h",
                     $time, got.cipher_byte, got.keystream_byte);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.cipher_byte !== want.cipher_byte) begin
            $display("%0t: cipher_byte mismatch, expected %02h, got %02h",
                     $time, want.cipher_byte, got.cipher_byte);
            errors++;
         end
         if (got.keystream_byte !== want.keystream_byte) begin
            $display("%0t: keystream_byte mismatch, expected %02h, got %02h",
                     $time, want.keystream_byte, got.keystream_byte);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rc4_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rc4_rsp_type rsp_data;

   rc4_scoreboard sb = new();
   int            idle_cycles = 0;
   int            items_sent = 0;
   int            burst_left = 0;

   rc4_stream_cipher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Both channels are sampled at the edge, before any of this step's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("rc4_stream_cipher regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // The receiver switches between stall patterns every so often.
   initial begin
      int mode;
      int run;
      forever begin
         mode = $urandom_range(0, 3);
         run = $urandom_range(1, 200);
         repeat (run) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task feed(input logic typ, input logic [7:0] value, input logic last);
      rc4_req_type it;
      if (burst_left == 0) begin
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      it.req_type = typ;
      it.byte_value = value;
      it.key_last = last;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // An idle edge first lets the monitor note the last accepted item.
   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task send_key(input int len, input bit finish);
      for (int k = 0; k < len; k++) begin
         feed(REQ_KEY, 8'($urandom_range(0, 255)), finish && (k == len - 1));
      end
   endtask

   task send_data(input int count);
      for (int k = 0; k < count; k++) begin
         feed(REQ_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
   endtask

   function int pick_key_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 16);
      if (r < 97) return $urandom_range(17, 64);
      return $urandom_range(65, KEY_MAX);
   endfunction

   initial begin
      int choice;
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Data before any key runs on the identity permutation.
      feed(REQ_DATA, 8'h00, 1'b0);
      feed(REQ_DATA, 8'hFF, 1'b1);
      feed(REQ_DATA, 8'hA5, 1'b0);
      // Single-byte keys at both extremes.
      feed(REQ_KEY, 8'h00, 1'b1);
      feed(REQ_DATA, 8'h00, 1'b0);
      feed(REQ_DATA, 8'hFF, 1'b0);
      feed(REQ_KEY, 8'hFF, 1'b1);
      feed(REQ_DATA, 8'h5A, 1'b1);
      feed(REQ_DATA, 8'hFF, 1'b0);
      // A short multi-byte key.
      feed(REQ_KEY, 8'hFF, 1'b0);
      feed(REQ_KEY, 8'h80, 1'b0);
      feed(REQ_KEY, 8'h01, 1'b1);
      feed(REQ_DATA, 8'h00, 1'b0);
      feed(REQ_DATA, 8'hFF, 1'b0);
      feed(REQ_DATA, 8'h81, 1'b1);
      // Data between key bytes uses the old permutation; the key stays pending.
      feed(REQ_KEY, 8'h12, 1'b0);
      feed(REQ_DATA, 8'h34, 1'b0);
      feed(REQ_DATA, 8'hC3, 1'b1);
      feed(REQ_KEY, 8'h56, 1'b1);
      feed(REQ_DATA, 8'h7E, 1'b0);
      feed(REQ_DATA, 8'h01, 1'b0);
      wait_drained();

      target = items_sent + RANDOM_ITEMS;
      // A key longer than the store, then enough data to wrap the generator index.
      send_key(KEY_MAX + 2, 1'b1);
      send_data($urandom_range(260, 280));
      while (items_sent < target) begin
         choice = $urandom_range(0, 99);
         if (choice < 60) begin
            send_key(pick_key_len(), 1'b1);
            send_data($urandom_range(1, 40));
         end else if (choice < 75) begin
            send_data($urandom_range(1, 30));
         end else if (choice < 90) begin
            send_key($urandom_range(1, 8), 1'b0);
            send_data($urandom_range(1, 10));
            send_key($urandom_range(1, 8), 1'b1);
            send_data($urandom_range(1, 20));
         end else if (choice < 95) begin
            send_key($urandom_range(1, 4), 1'b0);
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items, ran %0d key schedules (one key overran the store),",
               sb.requests_seen, sb.schedules_run);
      $display("checked %0d keystream results with random gaps and stalls.",
               sb.results_checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("rc4_stream_cipher regression: pass");
      end else begin
         $display("rc4_stream_cipher regression: fail");
      end
      $finish;
   end

endmodule
